@@ src/bitmap_contiguous_frame_allocator_core_assert.svh @@
// Assertion macros for the frame allocator core.
`ifndef BITMAP_CONTIGUOUS_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_CONTIGUOUS_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define BCFA_PROP(lbl, ck, rn, p, m) \
  lbl: assert property (@(posedge ck) disable iff (!rn) p) else $error(m);
`define BCFA_CHK(lbl, p, m) `BCFA_PROP(lbl, clk, rst_n, p, m)
`else
`define BCFA_PROP(lbl, ck, rn, p, m)
`define BCFA_CHK(lbl, p, m)
`endif
`endif

@@ src/bcfa_pkg.sv @@
// Shared types, constants and helpers of the frame allocator.
`timescale 1ns / 1ps
package bcfa_pkg;

  localparam int NUM_FRAMES = 1024;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = NUM_FRAMES / WORD_W;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int FRAME_W    = 10;
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 11;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [FRAME_W-1:0] start_frame;
    logic [LEN_W-1:0]   run_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] result_frame;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   free_count;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [BIT_W-1:0]  pos;
    logic [CNT_W-1:0]  carry;
  } fit_res_t;

  // Bits of word w covered by the run s..e.
  function automatic logic [WORD_W-1:0] run_mask(input logic [WIDX_W-1:0] w,
                                                 input logic [FRAME_W-1:0] s,
                                                 input logic [FRAME_W-1:0] e);
    logic [BIT_W-1:0]  lo;
    logic [BIT_W-1:0]  hi;
    logic [WORD_W-1:0] m;
    lo = (w == s[FRAME_W-1 -: WIDX_W]) ? s[BIT_W-1:0] : '0;
    hi = (w == e[FRAME_W-1 -: WIDX_W]) ? e[BIT_W-1:0] : '1;
    for (int k = 0; k < WORD_W; k++) begin
      m[k] = (BIT_W'(k) >= lo) && (BIT_W'(k) <= hi);
    end
    return m;
  endfunction

endpackage

@@ src/bcfa_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bcfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bcfa_word_fit.sv @@
// First-fit search of one map word, given the free run carried in from below.
`timescale 1ns / 1ps
module bcfa_word_fit import bcfa_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  logic [CNT_W-1:0]  carry,
  input  logic [LEN_W-1:0]  run_len,
  output fit_res_t          res
);

  always_comb begin
    logic [WORD_W-1:0] hit_v;
    logic              win_free;
    logic [CNT_W:0]    reach;
    logic [BIT_W-1:0]  top;
    hit_v    = '0;
    win_free = 1'b1;
    reach    = '0;
    top      = '0;
    // A run ending at bit j: every bit of the window up to and including j is free,
    // and the window plus the carried run reaches the length.
    for (int j = 0; j < WORD_W; j++) begin
      win_free = 1'b1;
      for (int k = 0; k < WORD_W; k++) begin
        if ((k <= j) && ((LEN_W+1)'(k) + {1'b0, run_len} > (LEN_W+1)'(j))) begin
          win_free = win_free & ~word[k];
        end
      end
      reach    = {1'b0, carry} + (CNT_W+1)'(j + 1);
      hit_v[j] = win_free && (reach >= {1'b0, run_len});
    end
    res.hit = |hit_v;
    res.pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_v[j]) begin
        res.pos = BIT_W'(j);
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (word[j]) begin
        top = BIT_W'(j);
      end
    end
    if (word == '0) begin
      res.carry = carry + CNT_W'(WORD_W);
    end else begin
      res.carry = CNT_W'(WORD_W - 1) - CNT_W'(top);
    end
  end

endmodule

@@ src/bitmap_contiguous_frame_allocator_core.sv @@
// Top level of the bitmap first-fit frame allocator.
`timescale 1ns / 1ps
`include "bitmap_contiguous_frame_allocator_core_assert.svh"
// Keeps a used bit for each of 1024 frames in a 32 x 32-bit RAM (one read
// port, one write port, registered read) plus an allocated count.
// Each row has a valid flop; an invalid row reads as all free, so reset and
// the clear operation empty the map at once with no sweep.
// One item is worked at a time; a new one is taken as soon as the previous
// result sits in the output register, even if that result is still stalled.
// Each item walks the map through the RAM: an allocate scans the words
// for a first fit, then reads and writes back each word the run touches;
// a free reads the word of its first frame and checks that frame, then
// reads and writes back each word the run touches (it stops after the
// check if the length is zero or the first frame is clear); clear and
// rejected items go straight to the result. The scan reads one word a
// cycle and tests it in the next.
// Status: ok, no free run (also for zero length), first frame not allocated,
// out of range (length over 1024, free past the last frame, opcode 3).
module bitmap_contiguous_frame_allocator_core import bcfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  state_t             state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [FRAME_W-1:0] st_r, st_nxt;
  logic [FRAME_W-1:0] end_r, end_nxt;
  logic [WIDX_W-1:0]  w_r, w_nxt;
  logic [WIDX_W:0]    rd_cnt_r, rd_cnt_nxt;
  logic               pipe_vld_r, pipe_vld_nxt;
  logic [WIDX_W-1:0]  pipe_idx_r, pipe_idx_nxt;
  logic [CNT_W-1:0]   carry_r, carry_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [NUM_WORDS-1:0] row_vld_r, row_vld_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [WIDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WIDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  rdq;
  fit_res_t           fit;
  logic [LEN_W:0]     free_end;
  logic [LEN_W-1:0]   tmp_frame;
  logic [WORD_W-1:0]  mask;

  bcfa_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Rows never written since the last clear read as all free.
  assign rdq = rd_vld_r ? ram_rdata : '0;

  bcfa_word_fit u_fit (
    .word    (rdq),
    .carry   (carry_r),
    .run_len (len_r),
    .res     (fit)
  );

  // Full-width end of a free run, so a long run past the map never wraps.
  assign free_end  = (LEN_W+1)'(in_data.start_frame) + (LEN_W+1)'(in_data.run_length);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    len_nxt      = len_r;
    st_nxt       = st_r;
    end_nxt      = end_r;
    w_nxt        = w_r;
    rd_cnt_nxt   = rd_cnt_r;
    pipe_vld_nxt = pipe_vld_r;
    pipe_idx_nxt = pipe_idx_r;
    carry_nxt    = carry_r;
    total_nxt    = total_r;
    row_vld_nxt  = row_vld_r;
    status_nxt   = status_r;
    frame_nxt    = frame_r;
    out_data_nxt = out_data_r;
    // Drop the output once it transfers.
    out_valid_nxt = out_valid_r && out_stall;
    ram_we       = 1'b0;
    ram_waddr    = w_r;
    ram_raddr    = w_r;
    tmp_frame    = '0;
    mask         = run_mask(w_r, st_r, end_r);
    ram_wdata    = (op_r == OP_ALLOC) ? (rdq | mask) : (rdq & ~mask);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          len_nxt    = in_data.run_length;
          st_nxt     = in_data.start_frame;
          frame_nxt  = '0;
          state_nxt  = S_DONE;
          case (in_data.operation)
            OP_ALLOC: begin
              if (in_data.run_length == '0) begin
                status_nxt = ST_NO_SPACE;
              end else if (in_data.run_length > LEN_W'(NUM_FRAMES)) begin
                status_nxt = ST_RANGE;
              end else begin
                rd_cnt_nxt   = '0;
                pipe_vld_nxt = 1'b0;
                carry_nxt    = '0;
                state_nxt    = S_SCAN;
              end
            end
            OP_FREE: begin
              if (free_end > (LEN_W+1)'(NUM_FRAMES)) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_FREE_RD;
              end
            end
            OP_CLEAR: begin
              row_vld_nxt = '0;
              total_nxt   = '0;
              status_nxt  = ST_OK;
            end
            default: begin
              status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one word a cycle; test the word read in the cycle before.
        ram_raddr = rd_cnt_r[WIDX_W-1:0];
        if (rd_cnt_r < (WIDX_W+1)'(NUM_WORDS)) begin
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_cnt_r[WIDX_W-1:0];
        end else begin
          pipe_vld_nxt = 1'b0;
        end
        if (pipe_vld_r) begin
          if (fit.hit) begin
            tmp_frame = {1'b0, pipe_idx_r, fit.pos} + 1'b1 - len_r;
            end_nxt   = {pipe_idx_r, fit.pos};
            st_nxt    = tmp_frame[FRAME_W-1:0];
            w_nxt     = tmp_frame[FRAME_W-1 -: WIDX_W];
            state_nxt = S_MARK_RD;
          end else if (pipe_idx_r == WIDX_W'(NUM_WORDS - 1)) begin
            status_nxt = ST_NO_SPACE;
            frame_nxt  = '0;
            state_nxt  = S_DONE;
          end else begin
            carry_nxt = fit.carry;
          end
        end
      end

      S_FREE_RD: begin
        ram_raddr = st_r[FRAME_W-1 -: WIDX_W];
        state_nxt = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (!rdq[st_r[BIT_W-1:0]]) begin
          status_nxt = ST_NOT_ALLOC;
          state_nxt  = S_DONE;
        end else if (len_r == '0) begin
          status_nxt = ST_OK;
          frame_nxt  = st_r;
          state_nxt  = S_DONE;
        end else begin
          tmp_frame = {1'b0, st_r} + len_r - 1'b1;
          end_nxt   = tmp_frame[FRAME_W-1:0];
          w_nxt     = st_r[FRAME_W-1 -: WIDX_W];
          state_nxt = S_MARK_RD;
        end
      end

      S_MARK_RD: begin
        ram_raddr = w_r;
        state_nxt = S_MARK_WR;
      end

      S_MARK_WR: begin
        // Set or clear the run's bits in this word and write it back.
        ram_we         = 1'b1;
        row_vld_nxt[w_r] = 1'b1;
        if (w_r == end_r[FRAME_W-1 -: WIDX_W]) begin
          if (op_r == OP_ALLOC) begin
            total_nxt = total_r + len_r;
          end else begin
            total_nxt = (total_r >= len_r) ? (total_r - len_r) : '0;
          end
          status_nxt = ST_OK;
          frame_nxt  = st_r;
          state_nxt  = S_DONE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_MARK_RD;
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status       = status_r;
          out_data_nxt.result_frame = frame_r;
          out_data_nxt.used_count   = total_r;
          out_data_nxt.free_count   = CNT_W'(NUM_FRAMES) - total_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_vld_nxt = row_vld_r[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      pipe_vld_r  <= 1'b0;
      total_r     <= '0;
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      total_r     <= total_nxt;
      row_vld_r   <= row_vld_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    len_r      <= len_nxt;
    st_r       <= st_nxt;
    end_r      <= end_nxt;
    w_r        <= w_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    carry_r    <= carry_nxt;
    status_r   <= status_nxt;
    frame_r    <= frame_nxt;
    out_data_r <= out_data_nxt;
  end

  `BCFA_CHK(a_count_sum, out_valid_r |-> (out_data_r.used_count + out_data_r.free_count == CNT_W'(NUM_FRAMES)), "used and free counts do not add up")
  `BCFA_CHK(a_total_max, total_r <= CNT_W'(NUM_FRAMES), "allocated count above frame total")
  `BCFA_CHK(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "not busy after a transfer")
  `BCFA_CHK(a_mark_window, (state_r == S_MARK_WR) |-> ((w_r >= st_r[FRAME_W-1 -: WIDX_W]) && (w_r <= end_r[FRAME_W-1 -: WIDX_W])), "write outside the run")

endmodule
